[sv/assert_macros.svh]
// Assertion helpers for the RTL files; only date_add_days includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/dad_pkg.sv]
package dad_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int ADD_W       = 16;
  localparam int COUNT_WIDTH = 16;

  // Day accumulator holds start day plus the full count.
  localparam int ACC_W = COUNT_WIDTH + 1;
  localparam int ALU_W = (ACC_W > YEAR_W) ? ACC_W : YEAR_W;

  localparam logic [ADD_W-1:0] ADD_MASK = ADD_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam int MOD_BASE  = 400;
  localparam int MOD_STEPS = 6;
  localparam int STEP_W    = 3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = {YEAR_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } dad_state_t;

  typedef struct packed {
    dad_state_t          state;
    logic [STEP_W-1:0]   step;
    logic                in_ready;
    logic                out_valid;
  } dad_ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_fire;
    logic date_ok;
    logic le;
  } dad_stat_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    begin
      case (m)
        4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
        4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
        default:                   len = DAY_W'(31);
      endcase
      return len;
    end
  endfunction

endpackage

[sv/dad_if.sv]
interface dad_in_if import dad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   start_day;
  logic [MONTH_W-1:0] start_month;
  logic [YEAR_W-1:0]  start_year;
  logic [ADD_W-1:0]   add_count;

  modport source (output valid, start_day, start_month, start_year, add_count,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, add_count,
                  output ready);
endinterface

interface dad_out_if import dad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   result_day;
  logic [MONTH_W-1:0] result_month;
  logic [YEAR_W-1:0]  result_year;
  logic               date_invalid;

  modport source (output valid, result_day, result_month, result_year, date_invalid,
                  input ready);
  modport sink   (input valid, result_day, result_month, result_year, date_invalid,
                  output ready);
endinterface

[sv/dad_alu.sv]
module dad_alu import dad_pkg::*; (
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] diff,
  output logic             le
);

  logic [ALU_W:0] wide;

  // One subtractor serves the year reduction, the date check and the month walk.
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[ALU_W-1:0];
  assign le   = wide[ALU_W] | (wide[ALU_W-1:0] == '0);

endmodule

[sv/dad_ctrl.sv]
module dad_ctrl import dad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dad_stat_t stat,
  output dad_ctrl_t ctrl
);

  dad_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (stat.in_fire) begin
          state_nxt = ST_MOD;
          step_nxt  = STEP_W'(MOD_STEPS - 1);
        end
      end
      ST_MOD: begin
        if (step_r == '0) begin
          state_nxt = ST_CHECK;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_CHECK: begin
        state_nxt = stat.date_ok ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        if (stat.le) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.state     = state_r;
    ctrl.step      = step_r;
    ctrl.in_ready  = (state_r == ST_IDLE);
    ctrl.out_valid = (state_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[sv/date_add_days.sv]
// Advances a Gregorian date by a day count, one item at a time. After an item
// is accepted the block first reduces the year modulo 400 with six
// shift-and-subtract steps, checks the date, and then walks
// forward one month per cycle, taking each month's length off the running day.
// The walk steps over up to about 2150 months for a 16-bit count; an invalid
// date skips it. A single shared subtractor serves the reduction, the check
// and the walk. The result is held until it is taken, and the next item is
// accepted in the cycle after that. An invalid date (day 0, month 0 or above
// 12, or a day past the end of its month) comes back unchanged with
// date_invalid set.
// Years wrap modulo 16384, and the leap rule is applied to the wrapped year.
module date_add_days import dad_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  dad_in_if.sink     in_ch,
  dad_out_if.source  out_ch
);

`include "assert_macros.svh"

  dad_ctrl_t ctrl;
  dad_stat_t stat;

  // Working registers; they double as the result register while the result waits.
  logic [ACC_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [ACC_W-1:0]   cnt_r, cnt_nxt;
  // Year modulo 400, kept in step with the year during the walk.
  logic [YEAR_W-1:0]  rem_r, rem_nxt;
  logic               inval_r, inval_nxt;

  logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
  logic               alu_le;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic               month_ok;

  dad_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  dad_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .le   (alu_le)
  );

  // A year is a leap year when its remainder modulo 400 is a multiple of four
  // other than 100, 200 or 300.
  assign leap = (rem_r[1:0] == 2'b00) && (rem_r != YEAR_W'(100)) &&
                (rem_r != YEAR_W'(200)) && (rem_r != YEAR_W'(300));
  assign len      = month_days(month_r, leap);
  assign month_ok = (month_r != '0) && (month_r <= MONTH_DEC);

  // Operand selection for the shared subtractor.
  always_comb begin
    if (ctrl.state == ST_MOD) begin
      alu_a = ALU_W'(rem_r);
      alu_b = ALU_W'(MOD_BASE) << ctrl.step;
    end else begin
      alu_a = ALU_W'(day_r);
      alu_b = ALU_W'(len);
    end
  end

  always_comb begin
    stat.in_fire  = in_ch.valid && ctrl.in_ready;
    stat.out_fire = ctrl.out_valid && out_ch.ready;
    stat.date_ok  = (day_r != '0) && month_ok && alu_le;
    stat.le       = alu_le;
  end

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    inval_nxt = inval_r;
    case (ctrl.state)
      ST_IDLE: begin
        if (stat.in_fire) begin
          day_nxt   = ACC_W'(in_ch.start_day);
          month_nxt = in_ch.start_month;
          year_nxt  = in_ch.start_year;
          cnt_nxt   = ACC_W'(in_ch.add_count & ADD_MASK);
          rem_nxt   = in_ch.start_year;
          inval_nxt = 1'b0;
        end
      end
      ST_MOD: begin
        // Restoring reduction: keep the difference when it did not borrow.
        if (!alu_le || alu_diff == '0) begin
          rem_nxt = alu_diff[YEAR_W-1:0];
        end
      end
      ST_CHECK: begin
        if (stat.date_ok) begin
          day_nxt = day_r + cnt_r;
        end else begin
          inval_nxt = 1'b1;
        end
      end
      ST_WALK: begin
        if (!alu_le) begin
          day_nxt = alu_diff[ACC_W-1:0];
          if (month_r == MONTH_DEC) begin
            month_nxt = MONTH_JAN;
            year_nxt  = year_r + YEAR_W'(1);
            if (year_r == YEAR_MAX || rem_r == YEAR_W'(MOD_BASE - 1)) begin
              rem_nxt = '0;
            end else begin
              rem_nxt = rem_r + YEAR_W'(1);
            end
          end else begin
            month_nxt = month_r + MONTH_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    inval_r <= inval_nxt;
  end

  assign in_ch.ready         = ctrl.in_ready;
  assign out_ch.valid        = ctrl.out_valid;
  assign out_ch.result_day   = day_r[DAY_W-1:0];
  assign out_ch.result_month = month_r;
  assign out_ch.result_year  = year_r;
  assign out_ch.date_invalid = inval_r;

  // After the reduction the remainder must lie below 400.
  `ASSERT_IMPL(a_rem_range, ctrl.state == ST_WALK, rem_r < YEAR_W'(MOD_BASE),
               "year remainder out of range")
  // The walk only ever sees a legal month.
  `ASSERT_IMPL(a_walk_month, ctrl.state == ST_WALK, month_ok,
               "month out of range during walk")
  // A valid result is a real calendar date.
  `ASSERT_IMPL(a_result_date, ctrl.out_valid && !inval_r,
               (day_r != '0) && alu_le && month_ok, "result is not a calendar date")
  // An accepted item always starts with the year reduction.
  `ASSERT_NEXT(a_start_mod, stat.in_fire,
               ctrl.state == ST_MOD && ctrl.step == STEP_W'(MOD_STEPS - 1),
               "item did not start reduction")

endmodule
